FILE: sv/ftcr_pkg.sv
// Shared types and codes for the frame table with clock replacement.
// Used by ftcr_cell, ftcr_ctrl and frame_table_clock_replacement; no dependencies.
package ftcr_pkg;

   // Width of the frame fields on the request and response buses
   localparam int FRAME_FIELD_W = 5;

   // Request kinds
   localparam logic [1:0] KIND_RESERVE       = 2'd0;
   localparam logic [1:0] KIND_FREE          = 2'd1;
   localparam logic [1:0] KIND_MARK_ACCESSED = 2'd2;
   localparam logic [1:0] KIND_MARK_MODIFIED = 2'd3;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FREE_SCAN,
      ST_CLOCK_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Commands broadcast to every cell
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN_FREE,
      CMD_SCAN_CLOCK,
      CMD_WRITE,
      CMD_RELEASE,
      CMD_MARK
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    mark_mod;
   } cell_ctl_type;

   typedef struct packed {
      logic free_hit;
      logic clock_hit;
   } cell_stat_type;

endpackage

FILE: sv/ftcr_cell.sv
// One frame of the table: used flag, owner page and process, accessed and
// modified marks, and the scan token passed to the next cell. Uses ftcr_pkg.
module ftcr_cell #(
   parameter int PAGE_BITS    = 16,
   parameter int PROCESS_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ftcr_pkg::cell_ctl_type    cell_ctl,
   input  logic                      start_sel,
   input  logic                      mark_sel,
   input  logic                      tok_prev,
   input  logic [PAGE_BITS-1:0]      cmd_page,
   input  logic [PROCESS_BITS-1:0]   cmd_process,
   output logic                      tok_out,
   output ftcr_pkg::cell_stat_type   stat,
   output logic [PAGE_BITS-1:0]      owner_page,
   output logic [PROCESS_BITS-1:0]   owner_process
);

   logic                    used_ff, used_in;
   logic                    acc_ff, acc_in;
   logic                    mod_ff, mod_in;
   logic                    tok_ff, tok_in;
   logic [PAGE_BITS-1:0]    page_ff, page_in;
   logic [PROCESS_BITS-1:0] proc_ff, proc_in;

   // Apply the broadcast command to this frame
   always_comb begin
      used_in = used_ff;
      acc_in  = acc_ff;
      mod_in  = mod_ff;
      tok_in  = tok_ff;
      page_in = page_ff;
      proc_in = proc_ff;
      case (cell_ctl.cmd)
         ftcr_pkg::CMD_LOAD: begin
            tok_in = start_sel;
         end
         ftcr_pkg::CMD_SCAN_FREE: begin
            tok_in = tok_prev;
         end
         ftcr_pkg::CMD_SCAN_CLOCK: begin
            tok_in = tok_prev;
            // Give a marked frame its second chance as the token leaves
            if (tok_ff) begin
               if (mod_ff) begin
                  mod_in = 1'b0;
               end else begin
                  acc_in = 1'b0;
                  mod_in = 1'b1;
               end
            end
         end
         ftcr_pkg::CMD_WRITE: begin
            if (tok_ff) begin
               used_in = 1'b1;
               page_in = cmd_page;
               proc_in = cmd_process;
               acc_in  = 1'b0;
               mod_in  = 1'b0;
            end
         end
         ftcr_pkg::CMD_RELEASE: begin
            if (used_ff && (proc_ff == cmd_process)) begin
               used_in = 1'b0;
               page_in = '0;
               proc_in = '0;
               acc_in  = 1'b0;
               mod_in  = 1'b0;
            end
         end
         ftcr_pkg::CMD_MARK: begin
            if (mark_sel) begin
               acc_in = 1'b1;
               if (cell_ctl.mark_mod) begin
                  mod_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control flags clear on reset, owner fields do not
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         acc_ff  <= 1'b0;
         mod_ff  <= 1'b0;
         tok_ff  <= 1'b0;
      end else begin
         used_ff <= used_in;
         acc_ff  <= acc_in;
         mod_ff  <= mod_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      proc_ff <= proc_in;
   end

   // Report status only while holding the token
   assign tok_out        = tok_ff;
   assign stat.free_hit  = tok_ff & ~used_ff;
   assign stat.clock_hit = tok_ff & ~acc_ff & ~mod_ff;
   assign owner_page     = tok_ff ? page_ff : '0;
   assign owner_process  = tok_ff ? proc_ff : '0;

endmodule

FILE: sv/ftcr_ctrl.sv
// Sequencer for the frame table: request capture, token walk control,
// victim pointer and the response register. Uses ftcr_pkg.
module ftcr_ctrl #(
   parameter int FRAME_COUNT  = 32,
   parameter int PAGE_BITS    = 16,
   parameter int PROCESS_BITS = 8,
   parameter int FRAME_W      = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic [PAGE_BITS-1:0]                 req_page,
   input  logic [PROCESS_BITS-1:0]              req_process,
   input  logic [ftcr_pkg::FRAME_FIELD_W-1:0]   req_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ftcr_pkg::FRAME_FIELD_W-1:0]   rsp_chosen,
   output logic                                 rsp_evicted,
   output logic [PAGE_BITS-1:0]                 rsp_page,
   output logic [PROCESS_BITS-1:0]              rsp_process,
   output ftcr_pkg::cell_ctl_type               cell_ctl,
   output logic [FRAME_W-1:0]                   start_idx,
   output logic [ftcr_pkg::FRAME_FIELD_W-1:0]   mark_idx,
   output logic [PAGE_BITS-1:0]                 cmd_page,
   output logic [PROCESS_BITS-1:0]              cmd_process,
   input  logic                                 free_hit,
   input  logic                                 clock_hit,
   input  logic [PAGE_BITS-1:0]                 owner_page,
   input  logic [PROCESS_BITS-1:0]              owner_process
);

   localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);

   ftcr_pkg::state_type state_ff, state_in;

   logic [1:0]                         kind_ff, kind_in;
   logic [PAGE_BITS-1:0]               page_ff, page_in;
   logic [PROCESS_BITS-1:0]            proc_ff, proc_in;
   logic [ftcr_pkg::FRAME_FIELD_W-1:0] frame_ff, frame_in;
   logic [FRAME_W-1:0]                 pos_ff, pos_in;
   logic [FRAME_W-1:0]                 victim_ff, victim_in;
   logic [FRAME_W-1:0]                 res_frame_ff, res_frame_in;
   logic                               res_ev_ff, res_ev_in;
   logic [PAGE_BITS-1:0]               res_page_ff, res_page_in;
   logic [PROCESS_BITS-1:0]            res_proc_ff, res_proc_in;
   logic                               out_valid_ff, out_valid_in;
   logic [ftcr_pkg::FRAME_FIELD_W-1:0] out_chosen_ff, out_chosen_in;
   logic                               out_ev_ff, out_ev_in;
   logic [PAGE_BITS-1:0]               out_page_ff, out_page_in;
   logic [PROCESS_BITS-1:0]            out_proc_ff, out_proc_in;

   logic        at_last;
   logic        mark_in_range;
   logic        out_free;
   logic [31:0] frame_wide;

   assign at_last       = (pos_ff == LAST_FRAME);
   assign mark_in_range = (32'(frame_ff) < FRAME_COUNT);
   assign out_free      = ~out_valid_ff | rsp_ready;
   assign frame_wide    = 32'(res_frame_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ftcr_pkg::ST_IDLE: begin
            if (req_valid) state_in = ftcr_pkg::ST_DECODE;
         end
         ftcr_pkg::ST_DECODE: begin
            if (kind_ff == ftcr_pkg::KIND_RESERVE) state_in = ftcr_pkg::ST_FREE_SCAN;
            else state_in = ftcr_pkg::ST_DONE;
         end
         ftcr_pkg::ST_FREE_SCAN: begin
            if (free_hit) state_in = ftcr_pkg::ST_WRITE;
            else if (at_last) state_in = ftcr_pkg::ST_CLOCK_SCAN;
         end
         ftcr_pkg::ST_CLOCK_SCAN: begin
            if (clock_hit) state_in = ftcr_pkg::ST_WRITE;
         end
         ftcr_pkg::ST_WRITE: begin
            state_in = ftcr_pkg::ST_DONE;
         end
         ftcr_pkg::ST_DONE: begin
            if (out_free) state_in = ftcr_pkg::ST_IDLE;
         end
         default: begin
            state_in = ftcr_pkg::ST_IDLE;
         end
      endcase
   end

   // Cell commands and request handshake
   always_comb begin
      req_ready         = 1'b0;
      cell_ctl.cmd      = ftcr_pkg::CMD_NONE;
      cell_ctl.mark_mod = (kind_ff == ftcr_pkg::KIND_MARK_MODIFIED);
      start_idx         = '0;
      case (state_ff)
         ftcr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ftcr_pkg::ST_DECODE: begin
            case (kind_ff)
               ftcr_pkg::KIND_RESERVE: cell_ctl.cmd = ftcr_pkg::CMD_LOAD;
               ftcr_pkg::KIND_FREE:    cell_ctl.cmd = ftcr_pkg::CMD_RELEASE;
               ftcr_pkg::KIND_MARK_ACCESSED, ftcr_pkg::KIND_MARK_MODIFIED: begin
                  if (mark_in_range) cell_ctl.cmd = ftcr_pkg::CMD_MARK;
               end
               default: cell_ctl.cmd = ftcr_pkg::CMD_NONE;
            endcase
         end
         ftcr_pkg::ST_FREE_SCAN: begin
            if (!free_hit) begin
               if (at_last) begin
                  // No free frame: restart the token at the victim pointer
                  cell_ctl.cmd = ftcr_pkg::CMD_LOAD;
                  start_idx    = victim_ff;
               end else begin
                  cell_ctl.cmd = ftcr_pkg::CMD_SCAN_FREE;
               end
            end
         end
         ftcr_pkg::ST_CLOCK_SCAN: begin
            if (!clock_hit) cell_ctl.cmd = ftcr_pkg::CMD_SCAN_CLOCK;
         end
         ftcr_pkg::ST_WRITE: begin
            cell_ctl.cmd = ftcr_pkg::CMD_WRITE;
         end
         default: begin
         end
      endcase
   end

   // Request capture, token position, result and response registers
   always_comb begin
      kind_in       = kind_ff;
      page_in       = page_ff;
      proc_in       = proc_ff;
      frame_in      = frame_ff;
      pos_in        = pos_ff;
      victim_in     = victim_ff;
      res_frame_in  = res_frame_ff;
      res_ev_in     = res_ev_ff;
      res_page_in   = res_page_ff;
      res_proc_in   = res_proc_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_chosen_in = out_chosen_ff;
      out_ev_in     = out_ev_ff;
      out_page_in   = out_page_ff;
      out_proc_in   = out_proc_ff;
      case (state_ff)
         ftcr_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               page_in  = req_page;
               proc_in  = req_process;
               frame_in = req_frame;
            end
         end
         ftcr_pkg::ST_DECODE: begin
            pos_in       = '0;
            res_frame_in = '0;
            res_ev_in    = 1'b0;
            res_page_in  = '0;
            res_proc_in  = '0;
         end
         ftcr_pkg::ST_FREE_SCAN: begin
            if (free_hit) res_frame_in = pos_ff;
            else if (at_last) pos_in = victim_ff;
            else pos_in = pos_ff + 1'b1;
         end
         ftcr_pkg::ST_CLOCK_SCAN: begin
            if (clock_hit) begin
               res_frame_in = pos_ff;
               res_ev_in    = 1'b1;
               res_page_in  = owner_page;
               res_proc_in  = owner_process;
               victim_in    = pos_ff;
            end else begin
               pos_in = at_last ? '0 : pos_ff + 1'b1;
            end
         end
         ftcr_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_chosen_in = frame_wide[ftcr_pkg::FRAME_FIELD_W-1:0];
               out_ev_in     = res_ev_ff;
               out_page_in   = res_page_ff;
               out_proc_in   = res_proc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftcr_pkg::ST_IDLE;
         victim_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         victim_ff    <= victim_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      page_ff       <= page_in;
      proc_ff       <= proc_in;
      frame_ff      <= frame_in;
      pos_ff        <= pos_in;
      res_frame_ff  <= res_frame_in;
      res_ev_ff     <= res_ev_in;
      res_page_ff   <= res_page_in;
      res_proc_ff   <= res_proc_in;
      out_chosen_ff <= out_chosen_in;
      out_ev_ff     <= out_ev_in;
      out_page_ff   <= out_page_in;
      out_proc_ff   <= out_proc_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_chosen  = out_chosen_ff;
   assign rsp_evicted = out_ev_ff;
   assign rsp_page    = out_page_ff;
   assign rsp_process = out_proc_ff;
   assign mark_idx    = frame_ff;
   assign cmd_page    = page_ff;
   assign cmd_process = proc_ff;

endmodule

FILE: sv/frame_table_clock_replacement.sv
// Top level of the frame table with clock replacement: a ring of ftcr_cell
// frames driven by ftcr_ctrl. Uses ftcr_pkg, ftcr_cell and ftcr_ctrl.
//
//   channel   direction  tdata (low bit up)                        tuser
//   req_      in         page_number, process_id, frame_index     kind
//   rsp_      out        chosen_frame, evicted, evicted_page,     -
//                        evicted_process
//
// Free and mark requests skip the scans and go from decode to the done state.
// A reserve walks a token one frame per cycle along the ring, first from
// frame 0 to the lowest free frame and, when the table is full, then from the
// clock hand past the frames it gives a second chance to, up to the victim.
// Reset is synchronous; every frame is free and the hand is at frame 0.
// A new request is taken once the previous one is finished, even while its
// response still waits in the output register for rsp_tready.
module frame_table_clock_replacement #(
   parameter int FRAME_COUNT  = 32,
   parameter int PAGE_BITS    = 16,
   parameter int PROCESS_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // page_number, process_id, frame_index, zero pad
   input  logic [((PAGE_BITS+PROCESS_BITS+ftcr_pkg::FRAME_FIELD_W+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // chosen_frame, evicted, evicted_page, evicted_process, zero pad
   output logic [((ftcr_pkg::FRAME_FIELD_W+1+PAGE_BITS+PROCESS_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int FW      = ftcr_pkg::FRAME_FIELD_W;
   localparam int RSP_PAD = ((FW + 1 + PAGE_BITS + PROCESS_BITS + 7) / 8) * 8;

   ftcr_pkg::cell_ctl_type  cell_ctl;
   ftcr_pkg::cell_stat_type stat [FRAME_COUNT];

   logic [FRAME_COUNT-1:0]  tok;
   logic [FRAME_COUNT-1:0]  free_vec;
   logic [FRAME_COUNT-1:0]  clock_vec;
   logic [PAGE_BITS-1:0]    cell_page [FRAME_COUNT];
   logic [PROCESS_BITS-1:0] cell_proc [FRAME_COUNT];
   logic [PAGE_BITS-1:0]    owner_page;
   logic [PROCESS_BITS-1:0] owner_process;
   logic [FRAME_W-1:0]      start_idx;
   logic [FW-1:0]           mark_idx;
   logic [PAGE_BITS-1:0]    cmd_page;
   logic [PROCESS_BITS-1:0] cmd_process;
   logic [FW-1:0]           rsp_chosen;
   logic                    rsp_evicted;
   logic [PAGE_BITS-1:0]    rsp_page;
   logic [PROCESS_BITS-1:0] rsp_process;

   ftcr_ctrl #(
      .FRAME_COUNT  (FRAME_COUNT),
      .PAGE_BITS    (PAGE_BITS),
      .PROCESS_BITS (PROCESS_BITS),
      .FRAME_W      (FRAME_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_kind      (req_tuser),
      .req_page      (req_tdata[PAGE_BITS-1:0]),
      .req_process   (req_tdata[PAGE_BITS +: PROCESS_BITS]),
      .req_frame     (req_tdata[PAGE_BITS+PROCESS_BITS +: FW]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_chosen    (rsp_chosen),
      .rsp_evicted   (rsp_evicted),
      .rsp_page      (rsp_page),
      .rsp_process   (rsp_process),
      .cell_ctl      (cell_ctl),
      .start_idx     (start_idx),
      .mark_idx      (mark_idx),
      .cmd_page      (cmd_page),
      .cmd_process   (cmd_process),
      .free_hit      (|free_vec),
      .clock_hit     (|clock_vec),
      .owner_page    (owner_page),
      .owner_process (owner_process)
   );

   // Ring of frame cells; each hands its token to the next one
   for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
      ftcr_cell #(
         .PAGE_BITS    (PAGE_BITS),
         .PROCESS_BITS (PROCESS_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_ctl      (cell_ctl),
         .start_sel     (start_idx == FRAME_W'(i)),
         .mark_sel      (32'(mark_idx) == 32'(i)),
         .tok_prev      (tok[(i + FRAME_COUNT - 1) % FRAME_COUNT]),
         .cmd_page      (cmd_page),
         .cmd_process   (cmd_process),
         .tok_out       (tok[i]),
         .stat          (stat[i]),
         .owner_page    (cell_page[i]),
         .owner_process (cell_proc[i])
      );
      assign free_vec[i]  = stat[i].free_hit;
      assign clock_vec[i] = stat[i].clock_hit;
   end

   // Collect the owner of the token cell; all others drive zero
   always_comb begin
      owner_page    = '0;
      owner_process = '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         owner_page    = owner_page | cell_page[i];
         owner_process = owner_process | cell_proc[i];
      end
   end

   assign rsp_tdata = RSP_PAD'({rsp_process, rsp_page, rsp_evicted, rsp_chosen});

`ifndef SYNTHESIS
   // At most one cell holds the scan token
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok))
      else $error("more than one frame holds the scan token");

   // Hits come only from the token cell, so at most one of each kind
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(free_vec) && $onehot0(clock_vec))
      else $error("more than one frame reports a scan hit");

   // A response without eviction carries no displaced owner
   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_evicted) |-> (rsp_page == '0 && rsp_process == '0))
      else $error("displaced owner reported without eviction");

   // Accepting a transaction closes the request side until it is done
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");
`endif

endmodule
